// File: src/month_calendar_layout_unit_assert.svh
// Assertion macros shared by the month calendar layout unit
`ifndef MONTH_CALENDAR_LAYOUT_UNIT_ASSERT_SVH
`define MONTH_CALENDAR_LAYOUT_UNIT_ASSERT_SVH

// Same-cycle implication, sampled on clk, off while in reset
`define MCL_ASSERT_SAME(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, sampled on clk, off while in reset
`define MCL_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: src/mcl_pkg.sv
// Shared types, constants and month tables for the month calendar layout unit
`timescale 1ns / 1ps

package mcl_pkg;

    // Request beat
    typedef struct packed {
        logic [3:0]  month;
        logic [13:0] year;
    } req_t;

    // Day cell beat
    typedef struct packed {
        logic [4:0] day_of_month;
        logic [2:0] week_row;
        logic [2:0] weekday;
        logic       bad_argument;
        logic       last;
    } cell_t;

    // Controller to datapath commands
    typedef struct packed {
        logic load;
        logic div;
        logic sum;
        logic mod;
        logic red;
        logic lay;
        logic advance;
    } cmd_t;

    // Datapath to controller status
    typedef struct packed {
        logic bad;
        logic last;
    } status_t;

    // Range limits of a request
    localparam logic [3:0]  MONTH_MIN = 4'd1;
    localparam logic [3:0]  MONTH_MAX = 4'd12;
    localparam logic [13:0] YEAR_MIN  = 14'd1;
    localparam logic [13:0] YEAR_MAX  = 14'd9999;

    // Calendar reform thresholds
    localparam logic [13:0] YEAR_REFORM   = 14'd1752;
    localparam logic [13:0] YEAR_CENTURY  = 14'd1800;
    localparam logic [13:0] BASE_CENTURY  = 14'd1701;
    localparam logic [13:0] BASE_QUADCENT = 14'd1601;

    // Month codes used in the layout
    localparam logic [3:0] MONTH_FEB = 4'd2;
    localparam logic [3:0] MONTH_SEP = 4'd9;

    // Reciprocals: x/100 = (x*5243)>>19 for x < 16384, x%7 via (x*37450)>>18
    localparam logic [12:0] DIV100_MUL   = 13'd5243;
    localparam int          DIV100_SHIFT = 19;
    localparam logic [15:0] DIV7_MUL     = 16'd37450;
    localparam int          DIV7_SHIFT   = 18;

    // Days dropped from the changeover September
    localparam logic [4:0] SKIP_FROM = 5'd2;
    localparam logic [4:0] SKIP_TO   = 5'd14;
    localparam logic [4:0] FEB_SHORT = 5'd28;

    // Month length with a 29-day February
    function automatic logic [4:0] month_len(input logic [3:0] m);
        logic [4:0] n;
        unique case (m)
            4'd2:                      n = 5'd29;
            4'd4, 4'd6, 4'd9, 4'd11:   n = 5'd30;
            default:                   n = 5'd31;
        endcase
        return n;
    endfunction

    // Days before the month, modulo 7, with a 29-day February
    function automatic logic [2:0] month_start_mod7(input logic [3:0] m);
        logic [2:0] r;
        unique case (m)
            4'd2:    r = 3'd3;
            4'd3:    r = 3'd4;
            4'd4:    r = 3'd0;
            4'd5:    r = 3'd2;
            4'd6:    r = 3'd5;
            4'd7:    r = 3'd0;
            4'd8:    r = 3'd3;
            4'd9:    r = 3'd6;
            4'd10:   r = 3'd1;
            4'd11:   r = 3'd4;
            4'd12:   r = 3'd6;
            default: r = 3'd0;
        endcase
        return r;
    endfunction

endpackage

// File: src/mcl_ctrl.sv
// Sequencing controller for the month calendar layout unit
`timescale 1ns / 1ps

module mcl_ctrl (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             req_valid,
    output logic             req_stall,
    output logic             cell_valid,
    input  logic             cell_stall,
    input  mcl_pkg::status_t status,
    output mcl_pkg::cmd_t    cmd
);

    typedef enum logic [6:0] {
        ST_IDLE = 7'b0000001,
        ST_DIV  = 7'b0000010,
        ST_SUM  = 7'b0000100,
        ST_MOD  = 7'b0001000,
        ST_RED  = 7'b0010000,
        ST_LAY  = 7'b0100000,
        ST_EMIT = 7'b1000000
    } state_t;

    state_t state_reg;
    state_t state_next;
    logic   req_beat;
    logic   cell_beat;

    assign req_stall  = (state_reg != ST_IDLE);
    assign cell_valid = (state_reg == ST_EMIT);
    assign req_beat   = req_valid && !req_stall;
    assign cell_beat  = cell_valid && !cell_stall;

    // Commands follow the state
    always_comb
    begin
        cmd         = '0;
        cmd.load    = req_beat;
        cmd.div     = (state_reg == ST_DIV) && !status.bad;
        cmd.sum     = (state_reg == ST_SUM);
        cmd.mod     = (state_reg == ST_MOD);
        cmd.red     = (state_reg == ST_RED);
        cmd.lay     = (state_reg == ST_LAY);
        cmd.advance = cell_beat && !status.last;
    end

    // Next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE: if (req_beat) state_next = ST_DIV;
            ST_DIV:  state_next = status.bad ? ST_EMIT : ST_SUM;
            ST_SUM:  state_next = ST_MOD;
            ST_MOD:  state_next = ST_RED;
            ST_RED:  state_next = ST_LAY;
            ST_LAY:  state_next = ST_EMIT;
            ST_EMIT: if (cell_beat && status.last) state_next = ST_IDLE;
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

endmodule

// File: src/mcl_datapath.sv
// Weekday arithmetic and day cell counters for the month calendar layout unit
`timescale 1ns / 1ps

module mcl_datapath (
    input  logic             clk,
    input  mcl_pkg::req_t    req_data,
    input  mcl_pkg::cmd_t    cmd,
    output mcl_pkg::status_t status,
    output mcl_pkg::cell_t   cell_data
);

    // Request registers
    logic [3:0]  month_reg;
    logic [13:0] year_reg;
    logic        bad_reg;
    logic        bad_next;

    // Two lanes: this year and the next
    logic [13:0] yr        [2];
    logic [7:0]  q100_reg  [2];
    logic [7:0]  q100_next [2];
    logic [5:0]  q400_reg  [2];
    logic [5:0]  q400_next [2];
    logic [13:0] d_reg     [2];
    logic [13:0] d_next    [2];
    logic [11:0] q7_reg    [2];
    logic [11:0] q7_next   [2];
    logic [2:0]  fw_reg    [2];
    logic [2:0]  fw_next   [2];

    // Cell counters
    logic [4:0] day_reg;
    logic [2:0] row_reg;
    logic [2:0] col_reg;
    logic [4:0] last_day_reg;
    logic       skip_reg;

    // Layout terms
    logic [2:0] diff;
    logic       feb_short;
    logic       changeover;
    logic [4:0] start_sum;
    logic [2:0] start_col;
    logic [4:0] len_next;

    assign yr[0] = year_reg;
    assign yr[1] = year_reg + 14'd1;

    // Range check of the incoming request
    assign bad_next = (req_data.month < mcl_pkg::MONTH_MIN)
                   || (req_data.month > mcl_pkg::MONTH_MAX)
                   || (req_data.year < mcl_pkg::YEAR_MIN)
                   || (req_data.year > mcl_pkg::YEAR_MAX);

    // Per-lane weekday of January 1, one step per command
    always_comb
    begin
        for (int l = 0; l < 2; l++)
        begin
            logic [13:0] off100;
            logic [11:0] off400;
            logic [26:0] p100;
            logic [24:0] p400;
            logic [13:0] base;
            logic [29:0] p7;
            logic [13:0] m7;

            off100 = yr[l] - mcl_pkg::BASE_CENTURY;
            off400 = 12'((yr[l] - mcl_pkg::BASE_QUADCENT) >> 2);
            p100   = 27'(off100) * 27'(mcl_pkg::DIV100_MUL);
            p400   = 25'(off400) * 25'(mcl_pkg::DIV100_MUL);
            q100_next[l] = p100[mcl_pkg::DIV100_SHIFT +: 8];
            q400_next[l] = p400[mcl_pkg::DIV100_SHIFT +: 6];

            // Julian count with century corrections
            base = 14'd4 + yr[l] + ((yr[l] + 14'd3) >> 2);
            if (yr[l] > mcl_pkg::YEAR_CENTURY)
            begin
                base = base - 14'(q100_reg[l]) + 14'(q400_reg[l]);
            end
            if (yr[l] > mcl_pkg::YEAR_REFORM)
            begin
                base = base + 14'd3;
            end
            d_next[l] = base;

            p7 = 30'(d_reg[l]) * 30'(mcl_pkg::DIV7_MUL);
            q7_next[l] = p7[mcl_pkg::DIV7_SHIFT +: 12];

            m7 = d_reg[l] - 14'(q7_reg[l]) * 14'd7;
            fw_next[l] = m7[2:0];
        end
    end

    // Leap and changeover decision, first column and month length
    always_comb
    begin
        diff       = (fw_reg[1] >= fw_reg[0]) ? (fw_reg[1] - fw_reg[0])
                                               : (fw_reg[1] + 3'd7 - fw_reg[0]);
        feb_short  = (diff == 3'd1);
        changeover = (diff != 3'd1) && (diff != 3'd2);

        start_sum = 5'(fw_reg[0]) + 5'(mcl_pkg::month_start_mod7(month_reg));
        if (feb_short && (month_reg > mcl_pkg::MONTH_FEB))
        begin
            start_sum = start_sum + 5'd6;   // one day fewer
        end
        if (changeover && (month_reg > mcl_pkg::MONTH_SEP))
        begin
            start_sum = start_sum + 5'd3;   // eleven days fewer
        end
        priority if (start_sum >= 5'd14)
        begin
            start_col = 3'(start_sum - 5'd14);
        end
        else if (start_sum >= 5'd7)
        begin
            start_col = 3'(start_sum - 5'd7);
        end
        else
        begin
            start_col = start_sum[2:0];
        end

        len_next = (feb_short && (month_reg == mcl_pkg::MONTH_FEB))
                 ? mcl_pkg::FEB_SHORT : mcl_pkg::month_len(month_reg);
    end

    // Datapath registers
    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            month_reg <= req_data.month;
            year_reg  <= req_data.year;
            bad_reg   <= bad_next;
            day_reg   <= '0;
            row_reg   <= '0;
            col_reg   <= '0;
        end
        for (int l = 0; l < 2; l++)
        begin
            if (cmd.div)
            begin
                q100_reg[l] <= q100_next[l];
                q400_reg[l] <= q400_next[l];
            end
            if (cmd.sum)
            begin
                d_reg[l] <= d_next[l];
            end
            if (cmd.mod)
            begin
                q7_reg[l] <= q7_next[l];
            end
            if (cmd.red)
            begin
                fw_reg[l] <= fw_next[l];
            end
        end
        if (cmd.lay)
        begin
            day_reg      <= 5'd1;
            row_reg      <= '0;
            col_reg      <= start_col;
            last_day_reg <= len_next;
            skip_reg     <= changeover && (month_reg == mcl_pkg::MONTH_SEP);
        end
        // Step to the next cell after each beat
        if (cmd.advance)
        begin
            day_reg <= (skip_reg && (day_reg == mcl_pkg::SKIP_FROM))
                     ? mcl_pkg::SKIP_TO : (day_reg + 5'd1);
            if (col_reg == 3'd6)
            begin
                col_reg <= '0;
                row_reg <= row_reg + 3'd1;
            end
            else
            begin
                col_reg <= col_reg + 3'd1;
            end
        end
    end

    assign status.bad  = bad_reg;
    assign status.last = bad_reg || (day_reg == last_day_reg);

    assign cell_data.day_of_month = day_reg;
    assign cell_data.week_row     = row_reg;
    assign cell_data.weekday      = col_reg;
    assign cell_data.bad_argument = bad_reg;
    assign cell_data.last         = status.last;

endmodule

// File: src/month_calendar_layout_unit.sv
// After the request beat the sequencer steps through DIV, SUM, MOD, RED and LAY, then emits
// day cells; a request out of range goes from DIV straight to a single error cell.
// A valid request yields 19 to 31 day cells, which leave one per cycle while cell_stall is low.
// A new request is taken no earlier than the cycle after the last cell beat.
// Reset (rst_n low, asynchronous) returns the sequencer to idle with no cell pending.
`timescale 1ns / 1ps

`include "month_calendar_layout_unit_assert.svh"

module month_calendar_layout_unit (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           req_valid,
    output logic           req_stall,
    input  mcl_pkg::req_t  req_data,
    output logic           cell_valid,
    input  logic           cell_stall,
    output mcl_pkg::cell_t cell_data
);

    mcl_pkg::cmd_t    cmd;
    mcl_pkg::status_t status;

    mcl_ctrl u_ctrl (
        .clk        (clk),
        .rst_n      (rst_n),
        .req_valid  (req_valid),
        .req_stall  (req_stall),
        .cell_valid (cell_valid),
        .cell_stall (cell_stall),
        .status     (status),
        .cmd        (cmd)
    );

    mcl_datapath u_datapath (
        .clk       (clk),
        .req_data  (req_data),
        .cmd       (cmd),
        .status    (status),
        .cell_data (cell_data)
    );

    // Error cell carries zeros and closes the request
    `MCL_ASSERT_SAME(a_bad_cell, cell_valid && cell_data.bad_argument,
                     (cell_data.day_of_month == 5'd0) && cell_data.last,
                     "error cell not zero or not last")
    // Day cells are numbered from 1 and sit in a real column
    `MCL_ASSERT_SAME(a_day_cell, cell_valid && !cell_data.bad_argument,
                     (cell_data.day_of_month != 5'd0) && (cell_data.weekday < 3'd7),
                     "day cell out of range")
    // No cell appears the cycle after a request beat
    `MCL_ASSERT_NEXT(a_no_early_cell, req_valid && !req_stall, !cell_valid,
                     "cell before weekday computed")
    // Cells keep coming until the last one is taken
    `MCL_ASSERT_NEXT(a_cells_continue, cell_valid && !cell_stall && !cell_data.last,
                     cell_valid, "cell stream broken before last")

endmodule
